// File: rtl/core/vibration_packet_axis_merger_macros.svh
// Assertion macros for the vibration packet axis merger checker.
`ifndef VIBRATION_PACKET_AXIS_MERGER_MACROS_SVH
`define VIBRATION_PACKET_AXIS_MERGER_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define VPAM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vpam check failed");

// Next-cycle implication, off while reset is low.
`define VPAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vpam check failed");

// Next-cycle implication that also runs during reset.
`define VPAM_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("vpam reset check failed");

`endif

// File: rtl/core/vpam_pkg.sv
// Shared types and constants of the vibration packet axis merger.
`default_nettype none

package vpam_pkg;

    localparam int CODE_W      = 3;
    localparam int OFFSET_W    = 10;
    localparam int POS_W       = 6;
    localparam int SAMPLE_W    = 16;
    localparam int PKT_W       = 10;
    localparam int NP_W        = 6;
    localparam int QUO_W       = 11;
    localparam int SLOT_W      = 10;
    localparam int CYCLE_W     = 16;
    localparam int VALUE_W     = 32;
    localparam int ADDR_FULL_W = 14;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_USED_W  = SLOT_W + CYCLE_W + 3 * VALUE_W;

    typedef logic [CODE_W-1:0] t_sensor;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gain;
        logic [SAMPLE_W-1:0]        zero;
        logic [SAMPLE_W-1:0]        sample;
        logic [POS_W-1:0]           pos;
        logic [OFFSET_W-1:0]        offset;
        logic [CODE_W-1:0]          code;
    } t_in_item;

    localparam int IN_ITEM_W = $bits(t_in_item);

    typedef struct packed {
        t_sensor                    sensor;
        logic [PKT_W-1:0]           packet;
        logic [QUO_W-1:0]           quo;
        logic [POS_W-1:0]           pos;
        logic [SAMPLE_W-1:0]        sample;
        logic [SAMPLE_W-1:0]        zero;
        logic signed [SAMPLE_W-1:0] gain;
    } t_dec_item;

    typedef struct packed {
        t_sensor                    sensor;
        logic [PKT_W-1:0]           packet;
        logic [NP_W-1:0]            np;
        logic [POS_W-1:0]           pos;
        logic [SAMPLE_W-1:0]        sample;
        logic [SAMPLE_W-1:0]        zero;
        logic signed [SAMPLE_W-1:0] gain;
    } t_hdr_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0]        sample;
        logic [SAMPLE_W-1:0]        zero;
        logic signed [SAMPLE_W-1:0] gain;
    } t_operand;

    typedef struct packed {
        logic                       kind;
        logic [SLOT_W-1:0]          slot;
        logic [CYCLE_W-1:0]         cycle;
        t_operand                   op_x;
        t_operand                   op_y;
        t_operand                   op_z;
    } t_trip_item;

endpackage

`default_nettype wire

// File: rtl/core/vpam_hdr_decode.sv
// Input register and header decode stages: sensor remap, packet number, next packet.
`default_nettype none

module vpam_hdr_decode
    import vpam_pkg::*;
#(
    parameter int SAMPLES_PER_PACKET = 64,
    parameter int PACKETS_PER_CYCLE  = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in,
    output logic           o_hdr_valid,
    input  wire logic      i_hdr_ready,
    output t_hdr_item      o_hdr
);

    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = QUO_W + RECIP_W;
    localparam int CYCLE_SPAN  = SAMPLES_PER_PACKET * PACKETS_PER_CYCLE;
    localparam logic [RECIP_W-1:0] RECIP_PKT =
        RECIP_W'(((1 << RECIP_SHIFT) + SAMPLES_PER_PACKET - 1) / SAMPLES_PER_PACKET);
    localparam logic [RECIP_W-1:0] RECIP_CYC =
        RECIP_W'(((1 << RECIP_SHIFT) + CYCLE_SPAN - 1) / CYCLE_SPAN);
    localparam logic [CODE_W-1:0] CODE_REMAP_FIRST = CODE_W'(5);
    localparam logic [CODE_W-1:0] CODE_REMAP_SHIFT = CODE_W'(2);

    logic      r_v0, r_v1, r_v2;
    t_in_item  r_s0;
    t_dec_item r_s1, n_s1;
    t_hdr_item r_s2, n_s2;
    logic      w_free0, w_free1, w_free2;

    logic [QUO_W-1:0]  w_num_pkt, w_num_nxt, w_wrap, w_np_full;
    logic [PROD_W-1:0] w_prod_pkt, w_prod_nxt;

    assign w_free2    = !r_v2 || i_hdr_ready;
    assign w_free1    = !r_v1 || w_free2;
    assign w_free0    = !r_v0 || w_free1;
    assign o_in_ready = w_free0;

    // packet = offset / SPP and (packet + 1) / PPC by reciprocal multiply
    always_comb begin
        w_num_pkt  = QUO_W'(r_s0.offset);
        w_num_nxt  = QUO_W'(r_s0.offset) + QUO_W'(SAMPLES_PER_PACKET);
        w_prod_pkt = PROD_W'(w_num_pkt) * PROD_W'(RECIP_PKT);
        w_prod_nxt = PROD_W'(w_num_nxt) * PROD_W'(RECIP_CYC);
        n_s1.sensor = (r_s0.code >= CODE_REMAP_FIRST) ? r_s0.code - CODE_REMAP_SHIFT
                                                      : r_s0.code;
        n_s1.packet = PKT_W'(w_prod_pkt >> RECIP_SHIFT);
        n_s1.quo    = QUO_W'(w_prod_nxt >> RECIP_SHIFT);
        n_s1.pos    = r_s0.pos;
        n_s1.sample = r_s0.sample;
        n_s1.zero   = r_s0.zero;
        n_s1.gain   = r_s0.gain;
    end

    // next packet = (packet + 1) mod PPC
    always_comb begin
        w_wrap    = QUO_W'(r_s1.quo * QUO_W'(PACKETS_PER_CYCLE));
        w_np_full = QUO_W'(r_s1.packet) + QUO_W'(1) - w_wrap;
        n_s2.sensor = r_s1.sensor;
        n_s2.packet = r_s1.packet;
        n_s2.np     = NP_W'(w_np_full);
        n_s2.pos    = r_s1.pos;
        n_s2.sample = r_s1.sample;
        n_s2.zero   = r_s1.zero;
        n_s2.gain   = r_s1.gain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_free0) r_v0 <= i_in_valid;
            if (w_free1) r_v1 <= r_v0;
            if (w_free2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free0) r_s0 <= i_in;
        if (w_free1) r_s1 <= n_s1;
        if (w_free2) r_s2 <= n_s2;
    end

    assign o_hdr_valid = r_v2;
    assign o_hdr       = r_s2;

endmodule

`default_nettype wire

// File: rtl/core/vpam_tracker.sv
// Packet sequence tracker, recovery, axis sample buffers and triple assembly.
`default_nettype none

module vpam_tracker
    import vpam_pkg::*;
#(
    parameter int SAMPLES_PER_PACKET = 64,
    parameter int PACKETS_PER_CYCLE  = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_hdr_valid,
    output logic            o_hdr_ready,
    input  wire t_hdr_item  i_hdr,
    output logic            o_trip_valid,
    input  wire logic       i_trip_ready,
    output t_trip_item      o_trip
);

    localparam int DEPTH = SAMPLES_PER_PACKET * PACKETS_PER_CYCLE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (PACKETS_PER_CYCLE > 1) ? $clog2(PACKETS_PER_CYCLE) : 1;
    localparam int POS_CMP_W = 9;
    localparam logic [POS_CMP_W-1:0] SPP_LIMIT = POS_CMP_W'(SAMPLES_PER_PACKET);
    localparam logic [POS_CMP_W-1:0] LAST_POS  = POS_CMP_W'(SAMPLES_PER_PACKET - 1);
    localparam logic [NP_W-1:0]      LAST_PKT  = NP_W'(PACKETS_PER_CYCLE - 1);
    localparam t_sensor LAST_SENSOR  = t_sensor'(5);
    localparam t_sensor ACCEL_FIRST  = t_sensor'(3);
    localparam t_sensor AXIS_X       = t_sensor'(0);
    localparam t_sensor AXIS_Y       = t_sensor'(1);

    logic [CODE_W-1:0]  r_es, n_es;
    logic [NP_W-1:0]    r_ep, n_ep;
    logic               r_rec, n_rec;
    logic               r_acc, n_acc;
    logic [CYCLE_W-1:0] r_cyc, n_cyc;

    logic [SAMPLE_W-1:0]   r_smp0_mem [DEPTH];
    logic [SAMPLE_W-1:0]   r_smp1_mem [DEPTH];
    logic [2*SAMPLE_W-1:0] r_par0_mem [PACKETS_PER_CYCLE];
    logic [2*SAMPLE_W-1:0] r_par1_mem [PACKETS_PER_CYCLE];

    logic                  r_v3;
    logic                  r_kind;
    logic [SLOT_W-1:0]     r_slot;
    logic [CYCLE_W-1:0]    r_cycv;
    t_operand              r_opz;
    logic [SAMPLE_W-1:0]   r_rd0, r_rd1;
    logic [2*SAMPLE_W-1:0] r_pd0, r_pd1;

    logic                   w_free3, w_move;
    logic                   w_pos0, w_match, w_skip, w_live, w_gen, w_wr0, w_wr1;
    t_sensor                w_axis;
    logic [ADDR_FULL_W-1:0] w_full;
    logic [AW-1:0]          w_addr;
    logic [PW-1:0]          w_paddr;

    function automatic t_sensor f_next_sensor(input t_sensor s);
        return (s == LAST_SENSOR) ? t_sensor'(0) : s + t_sensor'(1);
    endfunction

    assign w_free3     = !r_v3 || i_trip_ready;
    assign w_move      = i_hdr_valid && w_free3;
    assign o_hdr_ready = w_free3;

    assign w_full  = ADDR_FULL_W'(r_ep) * ADDR_FULL_W'(SAMPLES_PER_PACKET)
                   + ADDR_FULL_W'(i_hdr.pos);
    assign w_addr  = w_full[AW-1:0];
    assign w_paddr = r_ep[PW-1:0];

    always_comb begin
        n_es  = r_es;
        n_ep  = r_ep;
        n_rec = r_rec;
        n_acc = r_acc;
        n_cyc = r_cyc;
        w_gen = 1'b0;
        w_wr0 = 1'b0;
        w_wr1 = 1'b0;
        w_pos0  = (i_hdr.pos == '0);
        w_match = (i_hdr.sensor == r_es) && (i_hdr.packet == PKT_W'(r_ep));
        w_skip  = w_pos0 && (!w_match || r_rec);
        w_live  = (w_pos0 || r_acc) && (POS_CMP_W'(i_hdr.pos) < SPP_LIMIT);
        w_axis  = (r_es >= ACCEL_FIRST) ? r_es - ACCEL_FIRST : r_es;
        if (w_move) begin
            if (w_skip) begin
                // recovery: follow the header, skip the packet
                n_ep  = i_hdr.np;
                n_es  = (i_hdr.np == '0) ? f_next_sensor(i_hdr.sensor) : i_hdr.sensor;
                n_rec = !((n_es == '0) && (n_ep == '0));
                n_acc = 1'b0;
            end else begin
                if (w_pos0) n_acc = 1'b1;
                if (w_live) begin
                    case (w_axis)
                        AXIS_X:  w_wr0 = 1'b1;
                        AXIS_Y:  w_wr1 = 1'b1;
                        default: w_gen = 1'b1;
                    endcase
                    if (POS_CMP_W'(i_hdr.pos) == LAST_POS) begin
                        n_acc = 1'b0;
                        if (r_ep == LAST_PKT) begin
                            n_ep = '0;
                            n_es = f_next_sensor(r_es);
                            if (n_es == '0) n_cyc = r_cyc + CYCLE_W'(1);
                        end else begin
                            n_ep = r_ep + NP_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_es  <= '0;
            r_ep  <= '0;
            r_rec <= 1'b0;
            r_acc <= 1'b0;
            r_cyc <= '0;
            r_v3  <= 1'b0;
        end else begin
            r_es  <= n_es;
            r_ep  <= n_ep;
            r_rec <= n_rec;
            r_acc <= n_acc;
            r_cyc <= n_cyc;
            if (w_free3) r_v3 <= w_move && w_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move && w_wr0) begin
            r_smp0_mem[w_addr] <= i_hdr.sample;
            if (w_pos0) r_par0_mem[w_paddr] <= {i_hdr.zero, i_hdr.gain};
        end
        if (w_move && w_wr1) begin
            r_smp1_mem[w_addr] <= i_hdr.sample;
            if (w_pos0) r_par1_mem[w_paddr] <= {i_hdr.zero, i_hdr.gain};
        end
        if (w_move) begin
            r_rd0 <= r_smp0_mem[w_addr];
            r_rd1 <= r_smp1_mem[w_addr];
            r_pd0 <= r_par0_mem[w_paddr];
            r_pd1 <= r_par1_mem[w_paddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_kind       <= (r_es >= ACCEL_FIRST);
            r_slot       <= w_full[SLOT_W-1:0];
            r_cycv       <= r_cyc;
            r_opz.sample <= i_hdr.sample;
            r_opz.zero   <= i_hdr.zero;
            r_opz.gain   <= i_hdr.gain;
        end
    end

    always_comb begin
        o_trip.kind        = r_kind;
        o_trip.slot        = r_slot;
        o_trip.cycle       = r_cycv;
        o_trip.op_x.sample = r_rd0;
        o_trip.op_x.zero   = r_pd0[2*SAMPLE_W-1:SAMPLE_W];
        o_trip.op_x.gain   = r_pd0[SAMPLE_W-1:0];
        o_trip.op_y.sample = r_rd1;
        o_trip.op_y.zero   = r_pd1[2*SAMPLE_W-1:SAMPLE_W];
        o_trip.op_y.gain   = r_pd1[SAMPLE_W-1:0];
        o_trip.op_z        = r_opz;
    end

    assign o_trip_valid = r_v3;

endmodule

`default_nettype wire

// File: rtl/core/vpam_scale.sv
// Zero correction and gain scaling of the three axes, result register.
`default_nettype none

module vpam_scale
    import vpam_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_trip_valid,
    output logic             o_trip_ready,
    input  wire t_trip_item  i_trip,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_kind,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [CYCLE_W-1:0] o_cycle,
    output logic [VALUE_W-1:0] o_x,
    output logic [VALUE_W-1:0] o_y,
    output logic [VALUE_W-1:0] o_z
);

    logic               r_ov;
    logic               r_kind;
    logic [SLOT_W-1:0]  r_slot;
    logic [CYCLE_W-1:0] r_cycle;
    logic [VALUE_W-1:0] r_x, r_y, r_z;
    logic               w_load;

    function automatic logic [VALUE_W-1:0] f_scale(input t_operand op);
        logic signed [SAMPLE_W:0]   diff;
        logic signed [VALUE_W:0]    prod;
        diff = $signed({1'b0, op.sample}) - $signed({1'b0, op.zero});
        prod = diff * op.gain;
        return prod[VALUE_W-1:0];
    endfunction

    assign w_load       = !r_ov || i_ready;
    assign o_trip_ready = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= i_trip_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_trip_valid) begin
            r_kind  <= i_trip.kind;
            r_slot  <= i_trip.slot;
            r_cycle <= i_trip.cycle;
            r_x     <= f_scale(i_trip.op_x);
            r_y     <= f_scale(i_trip.op_y);
            r_z     <= f_scale(i_trip.op_z);
        end
    end

    assign o_valid = r_ov;
    assign o_kind  = r_kind;
    assign o_slot  = r_slot;
    assign o_cycle = r_cycle;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

`default_nettype wire

// File: rtl/core/vibration_packet_axis_merger.sv
// Vibration packet axis merger: checks packet sequence and merges three axes into triples.
// Usage:
//   Slave stream takes one sample request per cycle while s_axis_tready is high; tdata
//   carries the packet header (sensor code, sample offset), the sample position, the raw
//   sample, and the packet's zero level and gain. Samples of the first two channels of a
//   triple are buffered; each sample of the third channel yields one master request with
//   x, y, z scaled as (sample - zero) * gain, plus slot in cycle and cycle number; tuser
//   is 0 for angular rate, 1 for acceleration. Other samples yield nothing.
//   Stages: a request passes the input register, two header decode stages, the tracker
//   stage with buffer read, and the scaling and output register.
//   Throughput: one request per cycle while the master does not stall.
//   A stalled master holds its result; the pipeline keeps filling its empty stages and
//   s_axis_tready drops once every stage holds a request.
//   Reset (synchronous, active low) clears the sequence tracker, cycle count and all
//   valid flags; the sample buffers are not cleared and need no clearing pass.
`default_nettype none

module vibration_packet_axis_merger
    import vpam_pkg::*;
#(
    parameter int SAMPLES_PER_PACKET = 64,
    parameter int PACKETS_PER_CYCLE  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // sensor_code, sample_offset, sample_pos, raw_sample, zero_level, gain_q8
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // slot_in_cycle, cycle_number, x_value, y_value, z_value
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // kind
    output logic                        m_axis_tuser
);

    t_in_item   w_in;
    logic       w_hdr_valid, w_hdr_ready;
    t_hdr_item  w_hdr;
    logic       w_trip_valid, w_trip_ready;
    t_trip_item w_trip;
    logic [SLOT_W-1:0]  w_slot;
    logic [CYCLE_W-1:0] w_cycle;
    logic [VALUE_W-1:0] w_x, w_y, w_z;

    assign w_in = t_in_item'(s_axis_tdata[IN_ITEM_W-1:0]);

    vpam_hdr_decode #(
        .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET),
        .PACKETS_PER_CYCLE  (PACKETS_PER_CYCLE)
    ) u_hdr_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in        (w_in),
        .o_hdr_valid (w_hdr_valid),
        .i_hdr_ready (w_hdr_ready),
        .o_hdr       (w_hdr)
    );

    vpam_tracker #(
        .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET),
        .PACKETS_PER_CYCLE  (PACKETS_PER_CYCLE)
    ) u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hdr_valid  (w_hdr_valid),
        .o_hdr_ready  (w_hdr_ready),
        .i_hdr        (w_hdr),
        .o_trip_valid (w_trip_valid),
        .i_trip_ready (w_trip_ready),
        .o_trip       (w_trip)
    );

    vpam_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_trip_valid (w_trip_valid),
        .o_trip_ready (w_trip_ready),
        .i_trip       (w_trip),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_kind       (m_axis_tuser),
        .o_slot       (w_slot),
        .o_cycle      (w_cycle),
        .o_x          (w_x),
        .o_y          (w_y),
        .o_z          (w_z)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), w_z, w_y, w_x, w_cycle, w_slot};

endmodule

`default_nettype wire

// File: rtl/core/vpam_checker.sv
// Port-level checker for the vibration packet axis merger, bound to the top level.
`default_nettype none
`include "vibration_packet_axis_merger_macros.svh"

module vpam_checker
    import vpam_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    logic               r_seen;
    logic [CYCLE_W-1:0] r_last_cyc;
    logic [CYCLE_W-1:0] w_cyc, w_last_inc;
    logic               w_out_acc, w_m_stall, w_s_stall;

    assign w_cyc      = m_axis_tdata[SLOT_W+CYCLE_W-1:SLOT_W];
    assign w_last_inc = r_last_cyc + CYCLE_W'(1);
    assign w_out_acc  = m_axis_tvalid && m_axis_tready;
    assign w_m_stall  = m_axis_tvalid && !m_axis_tready;
    assign w_s_stall  = s_axis_tvalid && !s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_out_acc) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_acc) r_last_cyc <= w_cyc;
    end

    // no result right after reset
    `VPAM_ASSERT_RST(a_rst_no_valid, !i_rst_n, !m_axis_tvalid)
    // a stalled result holds
    `VPAM_ASSERT_NEXT(a_stall_hold, w_m_stall, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))
    // a stalled request holds
    `VPAM_ASSERT_NEXT(a_req_hold, w_s_stall, s_axis_tvalid && $stable(s_axis_tdata))
    // cycle number never jumps by more than one between results
    `VPAM_ASSERT_IMPL(a_cycle_step, w_out_acc && r_seen, w_cyc == r_last_cyc || w_cyc == w_last_inc)
    // tdata pad bits stay zero
    `VPAM_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)

endmodule

bind vibration_packet_axis_merger vpam_checker u_vpam_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking stream testbench for the vibration packet axis merger.
`timescale 1ns / 100ps

module tb_top;
    import vpam_pkg::*;

    localparam int SPP          = 64;
    localparam int PPC          = 16;
    localparam int NUM_CH       = 6;
    localparam int AXES         = 3;
    localparam int FIRST_ACCEL  = 3;
    localparam int REMAP_FIRST  = 5;
    localparam int REMAP_SHIFT  = 2;
    localparam int LAST_POS     = SPP - 1;
    localparam int STORE_DEPTH  = PPC * 2 * SPP;
    localparam int PARAM_DEPTH  = PPC * 2;
    localparam logic [CODE_W-1:0] RESYNC_CODE = 3'd7;
    localparam int TAIL_ITEMS   = 120;
    localparam int WATCHDOG     = 1000;
    localparam int DRAIN_CYCLES = 24;
    localparam int ITEM_GOAL    = 650;

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [CYCLE_W-1:0] cycle;
        logic [VALUE_W-1:0] x;
        logic [VALUE_W-1:0] y;
        logic [VALUE_W-1:0] z;
    } t_triple;

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   m_ready = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   m_user;

    vibration_packet_axis_merger dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sequence tracker copies: 0 steers generation, 1 follows accepted requests.
    logic [CODE_W-1:0]   trk_sensor [0:1];
    logic [3:0]          trk_packet [0:1];
    bit                  trk_recov  [0:1];
    bit                  trk_open   [0:1];
    logic [CYCLE_W-1:0]  trk_cycles [0:1];
    logic [SAMPLE_W-1:0] axis_mem   [0:1][0:STORE_DEPTH-1];
    logic [SAMPLE_W-1:0] zero_mem   [0:1][0:PARAM_DEPTH-1];
    logic [SAMPLE_W-1:0] gain_mem   [0:1][0:PARAM_DEPTH-1];
    bit                  axis_wr    [0:1][0:STORE_DEPTH-1];
    bit                  parm_wr    [0:1][0:PARAM_DEPTH-1];

    t_in_item sample_queue [$];
    t_triple  expected_triples [$];
    int       err_count = 0;
    int       n_used = 0;

    function automatic logic [VALUE_W-1:0] scaled(input logic [SAMPLE_W-1:0] smp,
                                                  input logic [SAMPLE_W-1:0] zr,
                                                  input logic signed [SAMPLE_W-1:0] gn);
        longint d;
        longint p;
        d = longint'(smp) - longint'(zr);
        p = d * longint'(gn);
        return p[VALUE_W-1:0];
    endfunction

    task automatic track_sample(input int m, input t_in_item it, output bit has_out,
                                output t_triple res, output bit unsafe, output bit used);
        logic [CODE_W-1:0] sensor;
        logic [CODE_W-1:0] es;
        logic [3:0]        pkt;
        logic [3:0]        ep;
        logic [3:0]        np;
        int                axis;
        logic [4:0]        pi;
        logic [10:0]       a0;
        logic [10:0]       a1;
        has_out = 1'b0;
        unsafe  = 1'b0;
        used    = 1'b0;
        res     = '0;
        sensor  = (it.code >= REMAP_FIRST) ? CODE_W'(it.code - REMAP_SHIFT) : it.code;
        pkt     = 4'(it.offset / SPP);
        if (it.pos == 0) begin
            used = 1'b1;
            es = trk_sensor[m];
            ep = trk_packet[m];
            if (sensor != es || pkt != ep) begin
                trk_recov[m] = 1'b1;
                es = sensor;
                ep = pkt;
            end
            if (trk_recov[m]) begin
                np = 4'((ep + 1) % PPC);
                if (np == 0)
                    es = (es == NUM_CH - 1) ? '0 : es + 1'b1;
                trk_sensor[m] = es;
                trk_packet[m] = np;
                trk_recov[m]  = !(es == 0 && np == 0);
                trk_open[m]   = 1'b0;
                return;
            end
            trk_open[m] = 1'b1;
        end
        if (!trk_open[m])
            return;
        used = 1'b1;
        axis = trk_sensor[m] % AXES;
        pi   = {trk_packet[m], 1'b0};
        if (axis < 2) begin
            a0 = {pi + 5'(axis), it.pos};
            axis_mem[m][a0] = it.sample;
            axis_wr[m][a0]  = 1'b1;
            if (it.pos == 0) begin
                zero_mem[m][pi + 5'(axis)] = it.zero;
                gain_mem[m][pi + 5'(axis)] = it.gain;
                parm_wr[m][pi + 5'(axis)]  = 1'b1;
            end
        end else begin
            a0 = {pi, it.pos};
            a1 = {pi | 5'd1, it.pos};
            if (!axis_wr[m][a0] || !axis_wr[m][a1] || !parm_wr[m][pi] ||
                !parm_wr[m][pi | 5'd1]) begin
                unsafe = 1'b1;
                return;
            end
            has_out   = 1'b1;
            res.kind  = (trk_sensor[m] >= FIRST_ACCEL);
            res.slot  = {trk_packet[m], it.pos};
            res.cycle = trk_cycles[m];
            res.x     = scaled(axis_mem[m][a0], zero_mem[m][pi], gain_mem[m][pi]);
            res.y     = scaled(axis_mem[m][a1], zero_mem[m][pi | 5'd1],
                               gain_mem[m][pi | 5'd1]);
            res.z     = scaled(it.sample, it.zero, it.gain);
        end
        if (it.pos == LAST_POS) begin
            np = 4'((trk_packet[m] + 1) % PPC);
            trk_packet[m] = np;
            if (np == 0) begin
                es = (trk_sensor[m] == NUM_CH - 1) ? '0 : trk_sensor[m] + 1'b1;
                trk_sensor[m] = es;
                if (es == 0)
                    trk_cycles[m] = trk_cycles[m] + 1'b1;
            end
            trk_open[m] = 1'b0;
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] rnd_val();
        case ($urandom_range(0, 19))
            0, 1: return 16'h0000;
            2, 3: return 16'hFFFF;
            4: return 16'h8000;
            5: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] hdr_code(input logic [CODE_W-1:0] sensor);
        if (sensor == NUM_CH - 1 || (sensor >= FIRST_ACCEL && $urandom_range(0, 1) == 1))
            return CODE_W'(sensor + REMAP_SHIFT);
        return sensor;
    endfunction

    function automatic t_in_item build(input logic [CODE_W-1:0] code,
                                       input logic [OFFSET_W-1:0] off,
                                       input logic [POS_W-1:0] pos,
                                       input logic [SAMPLE_W-1:0] smp,
                                       input logic [SAMPLE_W-1:0] zr,
                                       input logic [SAMPLE_W-1:0] gn);
        t_in_item it;
        it.code   = code;
        it.offset = off;
        it.pos    = pos;
        it.sample = smp;
        it.zero   = zr;
        it.gain   = gn;
        return it;
    endfunction

    // Queue a request unless it would read a buffer entry never written.
    task automatic try_push(input t_in_item it);
        logic [CODE_W-1:0]  s_es;
        logic [3:0]         s_ep;
        bit                 s_rc;
        bit                 s_op;
        logic [CYCLE_W-1:0] s_cy;
        bit                 has_out;
        bit                 unsafe;
        bit                 used;
        t_triple            res;
        s_es = trk_sensor[0];
        s_ep = trk_packet[0];
        s_rc = trk_recov[0];
        s_op = trk_open[0];
        s_cy = trk_cycles[0];
        track_sample(0, it, has_out, res, unsafe, used);
        if (unsafe) begin
            trk_sensor[0] = s_es;
            trk_packet[0] = s_ep;
            trk_recov[0]  = s_rc;
            trk_open[0]   = s_op;
            trk_cycles[0] = s_cy;
        end else begin
            sample_queue.push_back(it);
            if (used)
                n_used++;
        end
    endtask

    function automatic bit work_pending();
        return sample_queue.size() != 0 || s_valid || expected_triples.size() != 0;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    // Source side
    t_in_item drv_item = '0;
    int       src_gap = 0;
    bit       drv_has;
    bit       drv_unsafe;
    bit       drv_used;
    bit       drv_next;
    t_triple  drv_res;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                track_sample(1, drv_item, drv_has, drv_res, drv_unsafe, drv_used);
                if (drv_has)
                    expected_triples.push_back(drv_res);
            end
            if (!(s_valid && !s_ready)) begin
                drv_next = 1'b0;
                if (src_gap > 0) begin
                    src_gap--;
                end else if (sample_queue.size() != 0) begin
                    if (sample_queue.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0) begin
                        src_gap = $urandom_range(1, 17) - 1;
                    end else begin
                        drv_item = sample_queue.pop_front();
                        drv_next = 1'b1;
                    end
                end
                s_valid <= drv_next;
                s_data  <= {{(IN_TDATA_W - IN_ITEM_W){1'b0}}, drv_item};
            end
        end
    end

    // Sink side
    int      snk_gap = 0;
    bit      snk_rdy;
    t_triple mon_want;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_triples.size() == 0) begin
                    $error("unexpected triple: slot %0d", m_data[0 +: SLOT_W]);
                    err_count++;
                end else begin
                    mon_want = expected_triples.pop_front();
                    check_field("kind", VALUE_W'(mon_want.kind), VALUE_W'(m_user));
                    check_field("slot_in_cycle", VALUE_W'(mon_want.slot),
                                VALUE_W'(m_data[0 +: SLOT_W]));
                    check_field("cycle_number", VALUE_W'(mon_want.cycle),
                                VALUE_W'(m_data[SLOT_W +: CYCLE_W]));
                    check_field("x_value", mon_want.x,
                                m_data[SLOT_W + CYCLE_W +: VALUE_W]);
                    check_field("y_value", mon_want.y,
                                m_data[SLOT_W + CYCLE_W + VALUE_W +: VALUE_W]);
                    check_field("z_value", mon_want.z,
                                m_data[SLOT_W + CYCLE_W + 2 * VALUE_W +: VALUE_W]);
                end
            end
            snk_rdy = 1'b1;
            if (snk_gap > 0) begin
                snk_gap--;
                snk_rdy = 1'b0;
            end else if (sample_queue.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0) begin
                snk_gap = $urandom_range(1, 17) - 1;
                snk_rdy = 1'b0;
            end
            m_ready <= snk_rdy;
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (rst_n && work_pending()) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int                r;
        int                k;
        int                n_mid;
        logic [CODE_W-1:0] es;
        logic [3:0]        ep;
        for (int m = 0; m < 2; m++) begin
            trk_sensor[m] = '0;
            trk_packet[m] = '0;
            trk_recov[m]  = 1'b0;
            trk_open[m]   = 1'b0;
            trk_cycles[m] = '0;
        end

        // directed: extremes, ignored header fields, short packet, recovery, resync
        try_push(build(3'd0, 10'd0, 6'd0, 16'h0000, 16'hFFFF, 16'h8000));
        try_push(build(3'd7, 10'h3FF, 6'd31, 16'hFFFF, 16'h0000, 16'h7FFF));
        try_push(build(3'd2, 10'd5, 6'd63, 16'hFFFF, 16'h0000, 16'h7FFF));
        try_push(build(3'd0, 10'd127, 6'd0, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd4, 10'd700, 6'd5, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd0, 10'd64, 6'd0, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd1, 10'd0, 6'd63, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd5, 10'd192, 6'd0, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd2, 10'd512, 6'd10, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd3, 10'd256, 6'd0, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd6, 10'd320, 6'd0, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd1, 10'd400, 6'd0, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd4, 10'd900, 6'd0, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd6, 10'd960, 6'd0, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd7, 10'd3, 6'd0, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(RESYNC_CODE, 10'd1023, 6'd0, rnd_val(), rnd_val(), rnd_val()));
        try_push(build(3'd0, 10'd63, 6'd0, 16'hFFFF, 16'h0000, 16'h7FFF));
        try_push(build(3'd3, 10'd555, 6'd63, 16'h0000, 16'hFFFF, 16'h8000));

        // random: mostly well-formed packets, some broken headers and noise
        while (n_used < ITEM_GOAL) begin
            r  = $urandom_range(0, 99);
            es = trk_sensor[0];
            ep = trk_packet[0];
            if (trk_recov[0]) begin
                if (r < 35)
                    try_push(build(RESYNC_CODE, {4'(PPC - 1), 6'($urandom)}, 6'd0,
                                   rnd_val(), rnd_val(), rnd_val()));
                else if (r < 45)
                    try_push(build(3'($urandom), 10'($urandom), 6'd0,
                                   rnd_val(), rnd_val(), rnd_val()));
                else
                    try_push(build(hdr_code(es), {ep, 6'($urandom)}, 6'd0,
                                   rnd_val(), rnd_val(), rnd_val()));
                if (r > 90)
                    try_push(build(3'($urandom), 10'($urandom), 6'($urandom_range(1, 63)),
                                   rnd_val(), rnd_val(), rnd_val()));
            end else if (r < 1) begin
                try_push(build(3'($urandom), 10'($urandom), 6'd0,
                               rnd_val(), rnd_val(), rnd_val()));
                n_mid = $urandom_range(0, 3);
                for (k = 0; k < n_mid; k++)
                    try_push(build(3'($urandom), 10'($urandom), 6'($urandom_range(1, 63)),
                                   rnd_val(), rnd_val(), rnd_val()));
            end else if (r < 3) begin
                try_push(build(RESYNC_CODE, {4'(PPC - 1), 6'($urandom)}, 6'd0,
                               rnd_val(), rnd_val(), rnd_val()));
            end else if (r < 5) begin
                n_mid = $urandom_range(1, 3);
                for (k = 0; k < n_mid; k++)
                    try_push(build(3'($urandom), 10'($urandom), 6'($urandom_range(1, 63)),
                                   rnd_val(), rnd_val(), rnd_val()));
            end else begin
                try_push(build(hdr_code(es), {ep, 6'($urandom)}, 6'd0,
                               rnd_val(), rnd_val(), rnd_val()));
                n_mid = (r < 8) ? LAST_POS - 1 : $urandom_range(0, 5);
                for (k = 0; k < n_mid; k++)
                    try_push(build(3'($urandom), 10'($urandom),
                                   (r < 8) ? 6'(k + 1) : 6'($urandom_range(1, LAST_POS - 1)),
                                   rnd_val(), rnd_val(), rnd_val()));
                // short packet: header repeats on the next request
                if (!(r >= 8 && r < 12))
                    try_push(build(3'($urandom), 10'($urandom), 6'(LAST_POS),
                                   rnd_val(), rnd_val(), rnd_val()));
            end
        end

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        while (work_pending())
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/vpam_pkg.sv
rtl/core/vpam_hdr_decode.sv
rtl/core/vpam_tracker.sv
rtl/core/vpam_scale.sv
rtl/core/vibration_packet_axis_merger.sv
rtl/core/vpam_checker.sv
tb/tb_top.sv
